[sv/assert_macros.svh]
// Assertion macros for the RTL files; only rau_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define RAU_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define RAU_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define RAU_ASSERT(label, clk, rst, prop, msg)
`define RAU_NEVER(label, clk, rst, expr, msg)
`endif

`endif

[sv/rau_pkg.sv]
// Shared widths, codes, command/status types and helpers of the rational unit.
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int OUT_WIDTH     = 33;
   localparam int WIDE_WIDTH    = 64;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int SUM_WIDTH     = (2 * OPERAND_WIDTH + 1 > WIDE_WIDTH) ?
                                  WIDE_WIDTH : 2 * OPERAND_WIDTH + 1;
   localparam int SHIFT_WIDTH   = $clog2(SUM_WIDTH);
   localparam int DIV_CNT_WIDTH = $clog2(SUM_WIDTH);

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } rau_op_type;

   typedef enum logic [1:0] {
      MSEL_FIRST = 2'd0,
      MSEL_CROSS = 2'd1,
      MSEL_DEN   = 2'd2
   } rau_msel_type;

   typedef struct packed {
      logic         load;
      logic         mul_en;
      rau_msel_type mul_sel;
      logic         prep;
      logic         gcd_en;
      logic         gcd_fin;
      logic         div_en;
      logic         out_load;
      logic         out_err;
   } rau_cmd_type;

   typedef struct packed {
      logic den_zero;
      logic gcd_done;
   } rau_sts_type;

   function automatic logic [SUM_WIDTH-1:0] mag(input logic [SUM_WIDTH-1:0] x);
      return x[SUM_WIDTH-1] ? (~x + SUM_WIDTH'(1)) : x;
   endfunction

   // Sign-extend to the wide intermediate width, keep the low result bits.
   function automatic logic signed [OUT_WIDTH-1:0] fit_out(input logic [SUM_WIDTH-1:0] x);
      logic signed [SUM_WIDTH-1:0]  s;
      logic signed [WIDE_WIDTH-1:0] w;
      s = x;
      w = WIDE_WIDTH'(s);
      return w[OUT_WIDTH-1:0];
   endfunction

endpackage

[sv/rau_req_if.sv]
// Request channel: opcode and two signed fractions.
interface rau_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [1:0]                                opcode;
   logic signed [rau_pkg::OPERAND_WIDTH-1:0]  left_num;
   logic signed [rau_pkg::OPERAND_WIDTH-1:0]  left_den;
   logic signed [rau_pkg::OPERAND_WIDTH-1:0]  right_num;
   logic signed [rau_pkg::OPERAND_WIDTH-1:0]  right_den;

   modport source (output valid, opcode, left_num, left_den, right_num, right_den,
                   input ready);
   modport sink   (input valid, opcode, left_num, left_den, right_num, right_den,
                   output ready);
endinterface

[sv/rau_rsp_if.sv]
// Response channel: reduced fraction and zero-denominator flag.
interface rau_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [rau_pkg::OUT_WIDTH-1:0]  result_num;
   logic signed [rau_pkg::OUT_WIDTH-1:0]  result_den;
   logic                                  zero_den_error;

   modport source (output valid, result_num, result_den, zero_den_error, input ready);
   modport sink   (input valid, result_num, result_den, zero_den_error, output ready);
endinterface

[sv/rau_ctrl.sv]
// Sequencer of the rational unit: multiply, check, gcd, divide and output steps.
`include "assert_macros.svh"

module rau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rau_pkg::rau_sts_type sts,
   output rau_pkg::rau_cmd_type cmd
);
   import rau_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_MUL   = 6'b000010,
      ST_CHECK = 6'b000100,
      ST_GCD   = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_FIN   = 6'b100000
   } rau_state_type;

   localparam logic [DIV_CNT_WIDTH-1:0] DIV_LAST = DIV_CNT_WIDTH'(SUM_WIDTH - 1);

   rau_state_type              state_ff, state_in;
   rau_msel_type               msel_ff, msel_in;
   logic [DIV_CNT_WIDTH-1:0]   div_cnt_ff, div_cnt_in;
   logic                       err_ff, err_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      msel_in      = msel_ff;
      div_cnt_in   = div_cnt_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.mul_sel  = msel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               msel_in  = MSEL_FIRST;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            case (msel_ff)
               MSEL_FIRST: msel_in = MSEL_CROSS;
               MSEL_CROSS: msel_in = MSEL_DEN;
               default:    state_in = ST_CHECK;
            endcase
         end
         ST_CHECK: begin
            if (sts.den_zero) begin
               err_in   = 1'b1;
               state_in = ST_FIN;
            end else begin
               cmd.prep = 1'b1;
               err_in   = 1'b0;
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            if (sts.gcd_done) begin
               cmd.gcd_fin = 1'b1;
               div_cnt_in  = '0;
               state_in    = ST_DIV;
            end else begin
               cmd.gcd_en = 1'b1;
            end
         end
         ST_DIV: begin
            cmd.div_en = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = ST_FIN;
            end else begin
               div_cnt_in = div_cnt_ff + DIV_CNT_WIDTH'(1);
            end
         end
         ST_FIN: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_err  = err_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         msel_ff      <= MSEL_FIRST;
         div_cnt_ff   <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         msel_ff      <= msel_in;
         div_cnt_ff   <= div_cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RAU_NEVER(a_no_overwrite, clock, reset, cmd.out_load && rsp_valid_ff && !rsp_ready, "result overwritten before transfer")
   `RAU_ASSERT(a_accept_to_mul, clock, reset, (req_valid && req_ready) |=> (state_ff == ST_MUL), "accepted item did not start multiply")
   `RAU_ASSERT(a_div_starts_clean, clock, reset, (state_ff == ST_GCD && sts.gcd_done) |=> (state_ff == ST_DIV && div_cnt_ff == '0), "divide entered with stale count")
   `RAU_NEVER(a_gcd_fin_early, clock, reset, cmd.gcd_fin && !sts.gcd_done, "gcd finished before an operand reached zero")

endmodule

[sv/rau_dpath.sv]
// Datapath of the rational unit: shared multiplier, binary gcd, two exact dividers.
module rau_dpath (
   input  logic                                     clock,
   input  rau_pkg::rau_cmd_type                     cmd,
   output rau_pkg::rau_sts_type                     sts,
   input  logic [1:0]                               req_opcode,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] req_left_num,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] req_left_den,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] req_right_num,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0] req_right_den,
   output logic signed [rau_pkg::OUT_WIDTH-1:0]     rsp_result_num,
   output logic signed [rau_pkg::OUT_WIDTH-1:0]     rsp_result_den,
   output logic                                     rsp_zero_den_error
);
   import rau_pkg::*;

   rau_op_type                      op_ff, op_in;
   logic signed [OPERAND_WIDTH-1:0] ln_ff, ln_in, ld_ff, ld_in;
   logic signed [OPERAND_WIDTH-1:0] rn_ff, rn_in, rd_ff, rd_in;
   logic signed [SUM_WIDTH-1:0]     n_ff, n_in, d_ff, d_in;
   logic                            nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [SUM_WIDTH-1:0]            nq_ff, nq_in, dq_ff, dq_in;
   logic [SUM_WIDTH-1:0]            a_ff, a_in, b_ff, b_in;
   logic [SUM_WIDTH-1:0]            g_ff, g_in;
   logic [SHIFT_WIDTH-1:0]          k_ff, k_in;
   logic signed [OUT_WIDTH-1:0]     res_num_ff, res_num_in, res_den_ff, res_den_in;
   logic                            err_ff, err_in;

   logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
   logic signed [PROD_WIDTH-1:0]    prod;
   logic signed [SUM_WIDTH-1:0]     term;
   logic [SUM_WIDTH:0]              nt, dt, g_wide;
   logic                            nbit, dbit;
   logic [SUM_WIDTH-1:0]            n_signed, d_signed;

   assign sts.den_zero = (d_ff == '0);
   assign sts.gcd_done = (a_ff == '0) || (b_ff == '0);

   // operand select for the shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         MSEL_FIRST: begin
            mul_a = ln_ff;
            mul_b = (op_ff == OP_MUL) ? rn_ff : rd_ff;
         end
         MSEL_CROSS: begin
            mul_a = rn_ff;
            mul_b = ld_ff;
         end
         default: begin
            mul_a = ld_ff;
            mul_b = (op_ff == OP_DIV) ? rn_ff : rd_ff;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign term   = SUM_WIDTH'(prod);
   assign g_wide = {1'b0, g_ff};
   assign nt     = {a_ff, nq_ff[SUM_WIDTH-1]};
   assign dt     = {b_ff, dq_ff[SUM_WIDTH-1]};
   assign nbit   = (nt >= g_wide);
   assign dbit   = (dt >= g_wide);

   assign n_signed = nneg_ff ? (~nq_ff + SUM_WIDTH'(1)) : nq_ff;
   assign d_signed = dneg_ff ? (~dq_ff + SUM_WIDTH'(1)) : dq_ff;

   always_comb begin
      op_in      = op_ff;
      ln_in      = ln_ff;
      ld_in      = ld_ff;
      rn_in      = rn_ff;
      rd_in      = rd_ff;
      n_in       = n_ff;
      d_in       = d_ff;
      nneg_in    = nneg_ff;
      dneg_in    = dneg_ff;
      nq_in      = nq_ff;
      dq_in      = dq_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      g_in       = g_ff;
      k_in       = k_ff;
      res_num_in = res_num_ff;
      res_den_in = res_den_ff;
      err_in     = err_ff;

      if (cmd.load) begin
         op_in = rau_op_type'(req_opcode);
         ln_in = req_left_num;
         ld_in = req_left_den;
         rn_in = req_right_num;
         rd_in = req_right_den;
      end

      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MSEL_FIRST: n_in = term;
            MSEL_CROSS: begin
               if (op_ff == OP_ADD) begin
                  n_in = n_ff + term;
               end else if (op_ff == OP_SUB) begin
                  n_in = n_ff - term;
               end
            end
            default: d_in = term;
         endcase
      end

      if (cmd.prep) begin
         nneg_in = n_ff[SUM_WIDTH-1];
         dneg_in = d_ff[SUM_WIDTH-1];
         nq_in   = mag(n_ff);
         dq_in   = mag(d_ff);
         a_in    = mag(n_ff);
         b_in    = mag(d_ff);
         k_in    = '0;
      end

      // one binary gcd step: strip a factor of two, or halve the difference of two odd values
      if (cmd.gcd_en) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_in = a_ff >> 1;
            b_in = b_ff >> 1;
            k_in = k_ff + SHIFT_WIDTH'(1);
         end else if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end

      // one operand is zero: the other, shifted back, is the gcd; clear remainders
      if (cmd.gcd_fin) begin
         g_in = (a_ff | b_ff) << k_ff;
         a_in = '0;
         b_in = '0;
      end

      // restoring division, one quotient bit per cycle for each side
      if (cmd.div_en) begin
         a_in  = nbit ? SUM_WIDTH'(nt - g_wide) : nt[SUM_WIDTH-1:0];
         b_in  = dbit ? SUM_WIDTH'(dt - g_wide) : dt[SUM_WIDTH-1:0];
         nq_in = {nq_ff[SUM_WIDTH-2:0], nbit};
         dq_in = {dq_ff[SUM_WIDTH-2:0], dbit};
      end

      if (cmd.out_load) begin
         err_in     = cmd.out_err;
         res_num_in = cmd.out_err ? '0 : fit_out(n_signed);
         res_den_in = cmd.out_err ? '0 : fit_out(d_signed);
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      ln_ff      <= ln_in;
      ld_ff      <= ld_in;
      rn_ff      <= rn_in;
      rd_ff      <= rd_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      nneg_ff    <= nneg_in;
      dneg_ff    <= dneg_in;
      nq_ff      <= nq_in;
      dq_ff      <= dq_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      g_ff       <= g_in;
      k_ff       <= k_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
      err_ff     <= err_in;
   end

   assign rsp_result_num     = res_num_ff;
   assign rsp_result_den     = res_den_ff;
   assign rsp_zero_den_error = err_ff;

endmodule

[sv/rational_arithmetic_unit.sv]
// Top level of the rational fraction unit with gcd reduction.
//
//   channel   direction   contents
//   req_ch    in          opcode, left_num, left_den, right_num, right_den
//   rsp_ch    out         result_num, result_den, zero_den_error
//
// One item at a time: accept, multiply (first, cross and denominator products), check,
// gcd steps, gcd finish, divide and output.
// The binary gcd loop sets the spread from item to item; a zero numerator needs
// no gcd step.
// A zero denominator skips gcd and divide.
// Synchronous reset clears the sequencer and the output valid; the datapath needs none.
// A finished result waits in its last step while the output register still holds
// an earlier result that has not been transferred.
module rational_arithmetic_unit (
   input  logic      clock,
   input  logic      reset,
   rau_req_if.sink   req_ch,
   rau_rsp_if.source rsp_ch
);
   import rau_pkg::*;

   rau_cmd_type cmd;
   rau_sts_type sts;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rau_dpath u_dpath (
      .clock              (clock),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_ch.opcode),
      .req_left_num       (req_ch.left_num),
      .req_left_den       (req_ch.left_den),
      .req_right_num      (req_ch.right_num),
      .req_right_den      (req_ch.right_den),
      .rsp_result_num     (rsp_ch.result_num),
      .rsp_result_den     (rsp_ch.result_den),
      .rsp_zero_den_error (rsp_ch.zero_den_error)
   );

endmodule

[bench/rational_arithmetic_unit_test.sv]
// Self-checking testbench of the rational arithmetic unit: random and directed fraction ops.
module rational_arithmetic_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import rau_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 800;
   localparam int PHASE_ITEMS   = 450;
   localparam int DRAIN_CYCLES  = 150;

   typedef logic signed [OPERAND_WIDTH-1:0] operand_type;

   typedef struct {
      rau_op_type  op;
      operand_type left_num;
      operand_type left_den;
      operand_type right_num;
      operand_type right_den;
   } operand_pair_type;

   typedef struct {
      logic signed [OUT_WIDTH-1:0] num;
      logic signed [OUT_WIDTH-1:0] den;
      logic                        zero_den;
   } fraction_type;

   logic clock;
   logic reset;

   rau_req_if req_ch ();
   rau_rsp_if rsp_ch ();

   rational_arithmetic_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   operand_pair_type pending_pairs[$];
   fraction_type     expected_fractions[$];
   operand_pair_type next_pair;
   logic             pair_taken;
   int unsigned      send_idle_pct;
   int unsigned      rsp_stall_pct;
   int unsigned      hold_cycles_left;
   int unsigned      cycle_count;
   int unsigned      error_count;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Form the numerator and denominator products, then divide both by the gcd of their magnitudes.
   function automatic fraction_type reduce_fraction_op(input operand_pair_type p);
      logic signed [63:0] ln, ld, rn, rd, n, d;
      logic [63:0]        mag_n, mag_d, a, b, t, g, q;
      fraction_type       r;
      ln = 64'(p.left_num);
      ld = 64'(p.left_den);
      rn = 64'(p.right_num);
      rd = 64'(p.right_den);
      case (p.op)
         OP_ADD: begin
            n = ln * rd + rn * ld;
            d = ld * rd;
         end
         OP_SUB: begin
            n = ln * rd - rn * ld;
            d = ld * rd;
         end
         OP_MUL: begin
            n = ln * rn;
            d = ld * rd;
         end
         default: begin
            n = ln * rd;
            d = ld * rn;
         end
      endcase
      r.num      = '0;
      r.den      = '0;
      r.zero_den = 1'b1;
      if (d != 0) begin
         mag_n = (n < 0) ? -n : n;
         mag_d = (d < 0) ? -d : d;
         a = mag_n;
         b = mag_d;
         if (a == 0) begin
            g = b;
         end else begin
            while (b != 0) begin
               t = a % b;
               a = b;
               b = t;
            end
            g = a;
         end
         q = mag_n / g;
         q = (n < 0) ? -q : q;
         r.num = q[OUT_WIDTH-1:0];
         q = mag_d / g;
         q = (d < 0) ? -q : q;
         r.den = q[OUT_WIDTH-1:0];
         r.zero_den = 1'b0;
      end
      return r;
   endfunction

   function automatic operand_type random_operand();
      int unsigned pick;
      operand_type v;
      pick = $urandom_range(99);
      if (pick < 50) begin
         v = operand_type'($urandom());
      end else if (pick < 75) begin
         v = operand_type'($signed($urandom_range(20)) - 10);
      end else if (pick < 85) begin
         case ($urandom_range(3))
            0: v = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
            1: v = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};
            2: v = '0;
            default: v = '1;
         endcase
      end else begin
         // shared power-of-two factors give large gcds
         v = operand_type'(($signed($urandom_range(255)) - 128) <<< $urandom_range(7));
      end
      return v;
   endfunction

   function automatic operand_pair_type random_pair();
      operand_pair_type p;
      p.op        = rau_op_type'($urandom_range(3));
      p.left_num  = random_operand();
      p.left_den  = random_operand();
      p.right_num = random_operand();
      p.right_den = random_operand();
      if ($urandom_range(9) == 0) begin
         p.right_num = p.left_num;
         p.right_den = p.left_den;
      end
      return p;
   endfunction

   task automatic push_pair(input rau_op_type op, input int ln, input int ld,
                            input int rn, input int rd);
      operand_pair_type p;
      p.op        = op;
      p.left_num  = operand_type'(ln);
      p.left_den  = operand_type'(ld);
      p.right_num = operand_type'(rn);
      p.right_den = operand_type'(rd);
      pending_pairs.push_back(p);
   endtask

   // Step just past the rising edge, clear of the edge-triggered processes.
   task automatic settle();
      @(posedge clock);
      #1;
   endtask

   task automatic drain();
      while (pending_pairs.size() != 0 || req_ch.valid || expected_fractions.size() != 0)
         settle();
   endtask

   // Sender: drive at the falling edge, hold each item until its transfer.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || pair_taken) begin
         if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_pair = pending_pairs.pop_front();
            req_ch.valid     <= 1'b1;
            req_ch.opcode    <= next_pair.op;
            req_ch.left_num  <= next_pair.left_num;
            req_ch.left_den  <= next_pair.left_den;
            req_ch.right_num <= next_pair.right_num;
            req_ch.right_den <= next_pair.right_den;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus the long hold-off.
   always @(negedge clock) begin
      if (reset)
         rsp_ch.ready <= 1'b0;
      else
         rsp_ch.ready <= (hold_cycles_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (hold_cycles_left != 0)
         hold_cycles_left <= hold_cycles_left - 1;
   end

   // Check results first, then record the transfers on the request side.
   always @(posedge clock) begin : watch
      fraction_type     want;
      operand_pair_type seen;
      if (reset) begin
         pair_taken <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_fractions.size() == 0) begin
               flag_error($sformatf("unexpected result %0d/%0d",
                                    rsp_ch.result_num, rsp_ch.result_den));
            end else begin
               want = expected_fractions.pop_front();
               if (rsp_ch.result_num !== want.num)
                  flag_error($sformatf("result_num %0d, expected %0d",
                                       rsp_ch.result_num, want.num));
               if (rsp_ch.result_den !== want.den)
                  flag_error($sformatf("result_den %0d, expected %0d",
                                       rsp_ch.result_den, want.den));
               if (rsp_ch.zero_den_error !== want.zero_den)
                  flag_error($sformatf("zero_den_error %b, expected %b",
                                       rsp_ch.zero_den_error, want.zero_den));
            end
         end
         pair_taken <= req_ch.valid && req_ch.ready;
         if (req_ch.valid && req_ch.ready) begin
            seen.op        = rau_op_type'(req_ch.opcode);
            seen.left_num  = req_ch.left_num;
            seen.left_den  = req_ch.left_den;
            seen.right_num = req_ch.right_num;
            seen.right_den = req_ch.right_den;
            expected_fractions.push_back(reduce_fraction_op(seen));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rational_arithmetic_unit_test failed");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.opcode    = OP_ADD;
      req_ch.left_num  = '0;
      req_ch.left_den  = '0;
      req_ch.right_num = '0;
      req_ch.right_den = '0;
      rsp_ch.ready     = 1'b0;
      send_idle_pct    = 0;
      rsp_stall_pct    = 0;
      hold_cycles_left = 0;
      cycle_count      = 0;
      error_count      = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // directed: plain ops, zero denominators, zero numerators, sign cases, extremes
      push_pair(OP_ADD, 1, 2, 1, 3);
      push_pair(OP_SUB, 1, 2, 1, 2);
      push_pair(OP_MUL, 2, 3, 3, 4);
      push_pair(OP_DIV, 2, 3, 4, 5);
      push_pair(OP_ADD, 7, 0, 1, 3);
      push_pair(OP_SUB, 1, 3, 7, 0);
      push_pair(OP_MUL, 5, 0, 0, 9);
      push_pair(OP_DIV, 1, 3, 0, 5);
      push_pair(OP_DIV, 0, 0, 0, 0);
      push_pair(OP_MUL, 0, -5, 3, 1);
      push_pair(OP_SUB, 3, -4, -3, 4);
      push_pair(OP_ADD, 0, 7, 0, 3);
      push_pair(OP_ADD, -32768, 32767, -32768, 32765);
      push_pair(OP_ADD, 32767, -32768, 32767, -32768);
      push_pair(OP_ADD, -32768, -32768, -32768, -32768);
      push_pair(OP_SUB, 32767, -32768, -32768, 32767);
      push_pair(OP_MUL, 32767, 1, 32767, 1);
      push_pair(OP_MUL, -32768, 1, -32768, 1);
      push_pair(OP_DIV, -32768, 1, -1, 1);
      push_pair(OP_DIV, 32767, -32768, 32767, -32768);
      push_pair(OP_ADD, 5, 5, 5, 5);
      push_pair(OP_MUL, -1, -1, -1, -1);
      push_pair(OP_SUB, 21845, -21846, -21846, 21845);
      push_pair(OP_DIV, -21846, 21845, 21845, -21846);
      drain();

      // receiver holds off while the sender keeps offering; the unit backs up
      hold_cycles_left = HOLD_CYCLES;
      repeat (12) pending_pairs.push_back(random_pair());
      drain();

      for (int k = 0; k < 4; k++) begin
         case (k)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 71; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 71; end
            default: begin send_idle_pct = 14; rsp_stall_pct = 14; end
         endcase
         repeat (PHASE_ITEMS) pending_pairs.push_back(random_pair());
         drain();
      end

      repeat (DRAIN_CYCLES) settle();
      if (error_count == 0)
         $display("rational_arithmetic_unit_test passed");
      else
         $display("rational_arithmetic_unit_test failed");
      $finish;
   end

endmodule

[files.f]
+incdir+sv
sv/rau_pkg.sv
sv/rau_req_if.sv
sv/rau_rsp_if.sv
sv/rau_ctrl.sv
sv/rau_dpath.sv
sv/rational_arithmetic_unit.sv
bench/rational_arithmetic_unit_test.sv
